/* sv/mtte_pkg.sv */
// shared types, codes and key tables for the multi-tap text entry block
`timescale 1ns / 1ps

package mtte_pkg;

	// action codes
	localparam logic [1:0] ACT_KEY       = 2'd0;
	localparam logic [1:0] ACT_BACKSPACE = 2'd1;
	localparam logic [1:0] ACT_CLEAR     = 2'd2;

	// key codes
	localparam logic [3:0] NUM_KEYS = 4'd12;
	localparam logic [3:0] NO_KEY   = 4'd15;

	localparam logic [2:0] TAP_START = 3'd1;

	// result of one item
	typedef struct packed {
		logic [7:0] cursor_pos;
		logic [6:0] char_written;
		logic       wrote;
		logic       cleared_all;
		logic       leave_request;
	} mtte_res_t;

	// number of characters on each key
	function automatic logic [2:0] key_len(input logic [3:0] key);
		logic [2:0] len;
		case (key)
			4'd0, 4'd1, 4'd7, 4'd9: len = 3'd5;
			4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd8: len = 3'd4;
			4'd10: len = 3'd2;
			4'd11: len = 3'd1;
			default: len = 3'd0;
		endcase
		return len;
	endfunction

	// small modulo by repeated subtraction, values never exceed 5
	function automatic logic [2:0] mod_len(input logic [2:0] v, input logic [2:0] len);
		logic [2:0] r;
		r = v;
		for (int i = 0; i < 5; i++) begin
			if (len != 3'd0 && r >= len) begin
				r = r - len;
			end
		end
		if (len == 3'd0) begin
			r = 3'd0;
		end
		return r;
	endfunction

	// character list of each key
	function automatic logic [6:0] key_char(input logic [3:0] key, input logic [2:0] idx);
		logic [7:0] c;
		c = 8'd0;
		case (key)
			4'd0: begin
				case (idx)
					3'd0: c = "0"; 3'd1: c = "-"; 3'd2: c = "+"; 3'd3: c = "<"; 3'd4: c = ">";
					default: c = 8'd0;
				endcase
			end
			4'd1: begin
				case (idx)
					3'd0: c = "1"; 3'd1: c = "."; 3'd2: c = ","; 3'd3: c = "?"; 3'd4: c = "!";
					default: c = 8'd0;
				endcase
			end
			4'd2: begin
				case (idx)
					3'd0: c = "2"; 3'd1: c = "a"; 3'd2: c = "b"; 3'd3: c = "c";
					default: c = 8'd0;
				endcase
			end
			4'd3: begin
				case (idx)
					3'd0: c = "3"; 3'd1: c = "d"; 3'd2: c = "e"; 3'd3: c = "f";
					default: c = 8'd0;
				endcase
			end
			4'd4: begin
				case (idx)
					3'd0: c = "4"; 3'd1: c = "g"; 3'd2: c = "h"; 3'd3: c = "i";
					default: c = 8'd0;
				endcase
			end
			4'd5: begin
				case (idx)
					3'd0: c = "5"; 3'd1: c = "j"; 3'd2: c = "k"; 3'd3: c = "l";
					default: c = 8'd0;
				endcase
			end
			4'd6: begin
				case (idx)
					3'd0: c = "6"; 3'd1: c = "m"; 3'd2: c = "n"; 3'd3: c = "o";
					default: c = 8'd0;
				endcase
			end
			4'd7: begin
				case (idx)
					3'd0: c = "7"; 3'd1: c = "p"; 3'd2: c = "q"; 3'd3: c = "r"; 3'd4: c = "s";
					default: c = 8'd0;
				endcase
			end
			4'd8: begin
				case (idx)
					3'd0: c = "8"; 3'd1: c = "t"; 3'd2: c = "u"; 3'd3: c = "v";
					default: c = 8'd0;
				endcase
			end
			4'd9: begin
				case (idx)
					3'd0: c = "9"; 3'd1: c = "w"; 3'd2: c = "x"; 3'd3: c = "y"; 3'd4: c = "z";
					default: c = 8'd0;
				endcase
			end
			4'd10: begin
				case (idx)
					3'd0: c = "*"; 3'd1: c = " ";
					default: c = 8'd0;
				endcase
			end
			4'd11: begin
				case (idx)
					3'd0: c = "#";
					default: c = 8'd0;
				endcase
			end
			default: c = 8'd0;
		endcase
		return c[6:0];
	endfunction

endpackage

/* sv/multi_tap_text_entry.sv */
// multi-tap text entry for a 12-key phone pad, top level
`timescale 1ns / 1ps

// Multi-tap text entry. Each input item is a key press (action 0, key 0-9, star, hash, with a
// millisecond timestamp), a backspace (action 1) or a clear (action 2); each item gives exactly
// one result item with the cursor after the item, the character stored there, and flags for
// write/delete, clear and leave request. A press of the same key within repeat_timeout_ms of the
// previous press cycles that key's characters in place; any other press moves the cursor past an
// occupied cell (stopping at TEXT_LEN-1) and starts over at the key's second character (hash has
// only one, so it always writes hash).
// Timing: an item passes an input register and a result register, and a new item is taken
// every cycle while out_ready stays high; the longest path between the two registers is the
// 32-bit elapsed-time subtract and compare feeding the tap and character select. The text
// itself never has to be read back: cells below the cursor are always filled and cells above it
// always empty, so the message store reduces to the cursor and one occupied bit for the cell
// under it. Reset and clear therefore take effect at once, with no clearing pass. The timeout
// register is written through its own valid/ready port, which is always ready; write it only
// while no item is in flight.
module multi_tap_text_entry #(
	parameter int TEXT_LEN = 160
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] repeat_timeout_ms,
	// input items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [3:0]  key_index,
	input  logic [31:0] time_ms,
	// result items
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  cursor_pos,
	output logic [6:0]  char_written,
	output logic        wrote,
	output logic        cleared_all,
	output logic        leave_request
);

	import mtte_pkg::*;

	localparam int CUR_W = (TEXT_LEN > 1) ? $clog2(TEXT_LEN) : 1;
	localparam logic [CUR_W-1:0] LAST_CELL = CUR_W'(TEXT_LEN - 1);

	// configuration register
	logic [15:0] timeout_q;

	// input stage
	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [3:0]  key_s1;
	logic [31:0] time_s1;

	// result stage
	logic      valid_s2;
	mtte_res_t res_s2;

	// editor state
	logic [CUR_W-1:0] cursor_q;
	logic             occupied_q;   // cell under the cursor holds a character
	logic [2:0]       tap_q;
	logic [3:0]       prev_key_q;
	logic [31:0]      prev_time_q;

	// handshake
	logic adv_s1;

	// next state and result
	logic [CUR_W-1:0] cursor_d;
	logic             occupied_d;
	logic [2:0]       tap_d;
	logic [3:0]       prev_key_d;
	logic [31:0]      prev_time_d;
	mtte_res_t        res_d;

	logic             key_ok;
	logic [2:0]       len;
	logic [31:0]      elapsed;
	logic             repeat_hit;
	logic [2:0]       tap_new;
	logic [2:0]       char_idx;
	logic [6:0]       char_new;

	// stage 1 moves on when the result register is free or being emptied
	assign adv_s1    = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv_s1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 16'd1000;
		end else if (cfg_valid) begin
			timeout_q <= repeat_timeout_ms;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			key_s1    <= key_index;
			time_s1   <= time_ms;
		end
	end

	// key press decode
	always_comb begin
		key_ok     = (action_s1 == ACT_KEY) && (key_s1 < NUM_KEYS);
		len        = key_len(key_s1);
		elapsed    = time_s1 - prev_time_q;
		repeat_hit = (elapsed < {16'd0, timeout_q}) && (key_s1 == prev_key_q);
		tap_new    = repeat_hit ? mod_len(3'(tap_q + 3'd1), len) : TAP_START;
		char_idx   = mod_len(tap_new, len);
		char_new   = key_char(key_s1, char_idx);
	end

	// state update and result for the item in stage 1
	always_comb begin
		cursor_d    = cursor_q;
		occupied_d  = occupied_q;
		tap_d       = tap_q;
		prev_key_d  = prev_key_q;
		prev_time_d = prev_time_q;
		res_d       = '0;

		case (action_s1)
			ACT_KEY: begin
				if (key_ok) begin
					// new tap steps past a filled cell unless at the last one
					if (!repeat_hit && occupied_q && cursor_q != LAST_CELL) begin
						cursor_d = cursor_q + CUR_W'(1);
					end
					occupied_d         = 1'b1;
					tap_d              = tap_new;
					prev_key_d         = key_s1;
					prev_time_d        = time_s1;
					res_d.char_written = char_new;
					res_d.wrote        = 1'b1;
				end
			end
			ACT_BACKSPACE: begin
				if (cursor_q == '0) begin
					res_d.leave_request = 1'b1;
				end else begin
					// empty cell under cursor: delete the one before it
					if (!occupied_q) begin
						cursor_d = cursor_q - CUR_W'(1);
					end
					occupied_d  = 1'b0;
					tap_d       = TAP_START;
					prev_key_d  = NO_KEY;
					res_d.wrote = 1'b1;
				end
			end
			ACT_CLEAR: begin
				cursor_d          = '0;
				occupied_d        = 1'b0;
				tap_d             = TAP_START;
				prev_key_d        = NO_KEY;
				res_d.cleared_all = 1'b1;
			end
			default: begin
				// unused action, nothing changes
			end
		endcase

		res_d.cursor_pos = 8'(cursor_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			occupied_q  <= 1'b0;
			tap_q       <= TAP_START;
			prev_key_q  <= NO_KEY;
			prev_time_q <= 32'd0;
		end else if (adv_s1) begin
			cursor_q    <= cursor_d;
			occupied_q  <= occupied_d;
			tap_q       <= tap_d;
			prev_key_q  <= prev_key_d;
			prev_time_q <= prev_time_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid     = valid_s2;
	assign cursor_pos    = res_s2.cursor_pos;
	assign char_written  = res_s2.char_written;
	assign wrote         = res_s2.wrote;
	assign cleared_all   = res_s2.cleared_all;
	assign leave_request = res_s2.leave_request;

endmodule
